[rtl/three_channel_adc_ring_filter_defines.svh]
// Assertion macros of the ring filter RTL.
`ifndef THREE_CHANNEL_ADC_RING_FILTER_DEFINES_SVH
`define THREE_CHANNEL_ADC_RING_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and disabled while in reset.
`define TCARF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcarf assertion failed");
// Next-cycle implication, sampled on clk and disabled while in reset.
`define TCARF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcarf assertion failed");
`else
`define TCARF_ASSERT_IMP(lbl, ante, cons)
`define TCARF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[rtl/tcarf_pkg.sv]
// Package with the types and constants of the three-channel ring filter.
package tcarf_pkg;

  // Field widths.
  localparam int RAW_W = 10;
  localparam int BAT_W = 11;
  localparam int MOT_W = 10;
  localparam int SRV_W = 10;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_CAL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEEDER_MODE = 2'd1;
  localparam logic [SRV_W-1:0]     SERVO_CAL_RESET = 10'd600;
  localparam logic                 SEEDER_RESET    = 1'b1;

  // Motor offset and the fixed-point form of 0.27 (12 fraction bits).
  localparam logic [MOT_W-1:0] MOTOR_OFFSET = 10'd31;
  localparam logic [10:0]      COMP_MUL     = 11'd1106;
  localparam int               COMP_SHIFT   = 12;
  localparam int               COMP_PROD_W  = MOT_W + 11;

  // Default ring depths and battery preset.
  localparam int DEF_BATTERY_DEPTH  = 8;
  localparam int DEF_MOTOR_DEPTH    = 8;
  localparam int DEF_SERVO_DEPTH    = 8;
  localparam int DEF_BATTERY_PRESET = 512;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORR,
    ST_WALK,
    ST_HOLD
  } state_t;

endpackage

[rtl/tcarf_in_if.sv]
// Input channel: one sampling tick with three raw converter samples.
interface tcarf_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcarf_pkg::RAW_W-1:0]    battery_sample;
  logic [tcarf_pkg::RAW_W-1:0]    motor_sample;
  logic [tcarf_pkg::RAW_W-1:0]    servo_sample;

  modport source (output valid, battery_sample, motor_sample, servo_sample, input ready);
  modport sink   (input valid, battery_sample, motor_sample, servo_sample, output ready);
endinterface

[rtl/tcarf_out_if.sv]
// Result channel: corrected and filtered values of one tick.
interface tcarf_out_if;
  logic                           valid;
  logic                           ready;
  logic [tcarf_pkg::BAT_W-1:0]    battery_corrected;
  logic [tcarf_pkg::MOT_W-1:0]    motor_corrected;
  logic [tcarf_pkg::SRV_W-1:0]    servo_corrected;
  logic [tcarf_pkg::BAT_W-1:0]    battery_filtered;
  logic [tcarf_pkg::MOT_W-1:0]    motor_filtered;
  logic [tcarf_pkg::SRV_W-1:0]    servo_filtered;

  modport source (output valid, battery_corrected, motor_corrected, servo_corrected,
                  battery_filtered, motor_filtered, servo_filtered, input ready);
  modport sink   (input valid, battery_corrected, motor_corrected, servo_corrected,
                  battery_filtered, motor_filtered, servo_filtered, output ready);
endinterface

[rtl/tcarf_cfg_if.sv]
// Configuration write channel: register index and write data.
interface tcarf_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tcarf_pkg::CFG_IDX_W-1:0]     index;
  logic [tcarf_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/tcarf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcarf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/three_channel_adc_ring_filter.sv]
// Three-channel converter ring filter. Each accepted item carries one tick of battery,
// motor current and servo samples; the block corrects them (motor offset, servo
// inversion and motor-to-battery compensation in seeder mode), writes each into its
// own ring and returns the corrected values with the cascaded halving average of every
// ring. An item is accepted in the idle state; the correction state corrects it and
// writes the rings, and the walk state then walks the rings through their single read
// ports into one shared halving adder per ring. The result is registered at the end of
// the last walk cycle, and the next item can be accepted in the following cycle while
// that result waits in the output register. A walk that ends while the previous result
// has not yet been taken holds until the output register frees up. Ring entries not yet
// written read as their reset value through per-entry valid bits, so no clearing pass
// follows reset.
`include "three_channel_adc_ring_filter_defines.svh"

module three_channel_adc_ring_filter #(
  parameter int BATTERY_DEPTH  = tcarf_pkg::DEF_BATTERY_DEPTH,
  parameter int MOTOR_DEPTH    = tcarf_pkg::DEF_MOTOR_DEPTH,
  parameter int SERVO_DEPTH    = tcarf_pkg::DEF_SERVO_DEPTH,
  parameter int BATTERY_PRESET = tcarf_pkg::DEF_BATTERY_PRESET
) (
  input  logic        clk,
  input  logic        rst_n,
  tcarf_in_if.sink    in_ch,
  tcarf_out_if.source out_ch,
  tcarf_cfg_if.sink   cfg_ch
);
  localparam int BAT_W = tcarf_pkg::BAT_W;
  localparam int MOT_W = tcarf_pkg::MOT_W;
  localparam int SRV_W = tcarf_pkg::SRV_W;
  localparam int RAW_W = tcarf_pkg::RAW_W;

  localparam int MAX_AB    = (BATTERY_DEPTH > MOTOR_DEPTH) ? BATTERY_DEPTH : MOTOR_DEPTH;
  localparam int MAX_DEPTH = (MAX_AB > SERVO_DEPTH) ? MAX_AB : SERVO_DEPTH;
  localparam int CW        = $clog2(MAX_DEPTH + 1);
  localparam int BAT_AW    = (BATTERY_DEPTH > 1) ? $clog2(BATTERY_DEPTH) : 1;
  localparam int MOT_AW    = (MOTOR_DEPTH > 1) ? $clog2(MOTOR_DEPTH) : 1;
  localparam int SRV_AW    = (SERVO_DEPTH > 1) ? $clog2(SERVO_DEPTH) : 1;

  localparam logic [CW-1:0]     CNT_MAX   = CW'(MAX_DEPTH);
  localparam logic [CW-1:0]     BAT_D     = CW'(BATTERY_DEPTH);
  localparam logic [CW-1:0]     MOT_D     = CW'(MOTOR_DEPTH);
  localparam logic [CW-1:0]     SRV_D     = CW'(SERVO_DEPTH);
  localparam logic [BAT_AW-1:0] BAT_LAST  = BAT_AW'(BATTERY_DEPTH - 1);
  localparam logic [MOT_AW-1:0] MOT_LAST  = MOT_AW'(MOTOR_DEPTH - 1);
  localparam logic [SRV_AW-1:0] SRV_LAST  = SRV_AW'(SERVO_DEPTH - 1);
  localparam logic [BAT_W-1:0]  BAT_RESET = BAT_W'(BATTERY_PRESET);

  // Sequencer and control.
  tcarf_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     cnt_r;
  logic              in_ready, ring_we, walking, walk_done, out_free, load_out;

  // Configuration registers.
  logic [SRV_W-1:0]  servo_cal_r;
  logic              seeder_r;

  // Captured samples and corrected values.
  logic [RAW_W-1:0]  bat_smp_r, mot_smp_r, srv_smp_r;
  logic [BAT_W-1:0]  bat_cor, bat_cor_r;
  logic [MOT_W-1:0]  mot_cor, mot_cor_r;
  logic [SRV_W-1:0]  srv_cor, srv_cor_r;
  logic [tcarf_pkg::COMP_PROD_W-1:0] comp_prod;
  logic [MOT_W-1:0]  last_mot_avg_r;

  // Ring slots, valid bits and read side.
  logic [BAT_AW-1:0]        bat_slot_r, bat_raddr;
  logic [MOT_AW-1:0]        mot_slot_r, mot_raddr;
  logic [SRV_AW-1:0]        srv_slot_r, srv_raddr;
  logic [BATTERY_DEPTH-1:0] bat_vld_r;
  logic [MOTOR_DEPTH-1:0]   mot_vld_r;
  logic [SERVO_DEPTH-1:0]   srv_vld_r;
  logic [BAT_W-1:0]         bat_rdata, bat_rd;
  logic [MOT_W-1:0]         mot_rdata, mot_rd;
  logic [SRV_W-1:0]         srv_rdata, srv_rd;
  logic                     bat_vq_r, mot_vq_r, srv_vq_r;
  logic                     bat_take_r, mot_take_r, srv_take_r, first_r;

  // Halving accumulators.
  logic [BAT_W-1:0]  bat_acc_r, bat_acc_nxt;
  logic [MOT_W-1:0]  mot_acc_r, mot_acc_nxt;
  logic [SRV_W-1:0]  srv_acc_r, srv_acc_nxt;
  logic [BAT_W:0]    bat_sum;
  logic [MOT_W:0]    mot_sum;
  logic [SRV_W:0]    srv_sum;

  // Output register.
  logic              out_valid_r;
  logic [BAT_W-1:0]  out_bat_cor_r, out_bat_flt_r;
  logic [MOT_W-1:0]  out_mot_cor_r, out_mot_flt_r;
  logic [SRV_W-1:0]  out_srv_cor_r, out_srv_flt_r;

  assign walk_done = (cnt_r == CNT_MAX);
  assign out_free  = !out_valid_r || out_ch.ready;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcarf_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = tcarf_pkg::ST_CORR;
      end
      tcarf_pkg::ST_CORR: state_nxt = tcarf_pkg::ST_WALK;
      tcarf_pkg::ST_WALK: begin
        if (walk_done) state_nxt = out_free ? tcarf_pkg::ST_IDLE : tcarf_pkg::ST_HOLD;
      end
      tcarf_pkg::ST_HOLD: begin
        if (out_free) state_nxt = tcarf_pkg::ST_IDLE;
      end
      default: state_nxt = tcarf_pkg::ST_IDLE;
    endcase
  end

  // State-driven control outputs.
  always_comb begin
    in_ready = 1'b0;
    ring_we  = 1'b0;
    walking  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      tcarf_pkg::ST_IDLE: in_ready = 1'b1;
      tcarf_pkg::ST_CORR: ring_we  = 1'b1;
      tcarf_pkg::ST_WALK: begin
        walking  = 1'b1;
        load_out = walk_done && out_free;
      end
      tcarf_pkg::ST_HOLD: load_out = out_free;
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign cfg_ch.ready = 1'b1;

  // State register and walk counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcarf_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ring_we) begin
        cnt_r <= '0;
      end else if (walking && !walk_done) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_cal_r <= tcarf_pkg::SERVO_CAL_RESET;
      seeder_r    <= tcarf_pkg::SEEDER_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        tcarf_pkg::CFG_SERVO_CAL:   servo_cal_r <= cfg_ch.data[SRV_W-1:0];
        tcarf_pkg::CFG_SEEDER_MODE: seeder_r    <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Capture the samples of an accepted item.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      bat_smp_r <= in_ch.battery_sample;
      mot_smp_r <= in_ch.motor_sample;
      srv_smp_r <= in_ch.servo_sample;
    end
  end

  // Corrections: battery compensation from the previous motor average, motor offset and servo inversion.
  assign comp_prod = tcarf_pkg::COMP_PROD_W'(last_mot_avg_r)
                   * tcarf_pkg::COMP_PROD_W'(tcarf_pkg::COMP_MUL);

  always_comb begin
    bat_cor = BAT_W'(bat_smp_r);
    if (seeder_r) begin
      bat_cor = BAT_W'(bat_smp_r)
              + BAT_W'(comp_prod[tcarf_pkg::COMP_PROD_W-1:tcarf_pkg::COMP_SHIFT]);
    end
    mot_cor = (mot_smp_r > tcarf_pkg::MOTOR_OFFSET) ? (mot_smp_r - tcarf_pkg::MOTOR_OFFSET)
                                                     : '0;
    srv_cor = srv_smp_r;
    if (seeder_r) begin
      srv_cor = (srv_smp_r > servo_cal_r) ? servo_cal_r : (servo_cal_r - srv_smp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      bat_cor_r <= bat_cor;
      mot_cor_r <= mot_cor;
      srv_cor_r <= srv_cor;
    end
  end

  // Write slots and per-entry valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bat_slot_r <= '0;
      mot_slot_r <= '0;
      srv_slot_r <= '0;
      bat_vld_r  <= '0;
      mot_vld_r  <= '0;
      srv_vld_r  <= '0;
    end else if (ring_we) begin
      bat_slot_r <= (bat_slot_r == BAT_LAST) ? '0 : bat_slot_r + 1'b1;
      mot_slot_r <= (mot_slot_r == MOT_LAST) ? '0 : mot_slot_r + 1'b1;
      srv_slot_r <= (srv_slot_r == SRV_LAST) ? '0 : srv_slot_r + 1'b1;
      bat_vld_r[bat_slot_r] <= 1'b1;
      mot_vld_r[mot_slot_r] <= 1'b1;
      srv_vld_r[srv_slot_r] <= 1'b1;
    end
  end

  // Walk addresses, clamped for rings shorter than the walk.
  assign bat_raddr = (cnt_r < BAT_D) ? BAT_AW'(cnt_r) : '0;
  assign mot_raddr = (cnt_r < MOT_D) ? MOT_AW'(cnt_r) : '0;
  assign srv_raddr = (cnt_r < SRV_D) ? SRV_AW'(cnt_r) : '0;

  tcarf_ram #(.WIDTH(BAT_W), .DEPTH(BATTERY_DEPTH)) u_bat_ram (
    .clk(clk), .we(ring_we), .waddr(bat_slot_r), .wdata(bat_cor),
    .raddr(bat_raddr), .rdata(bat_rdata)
  );
  tcarf_ram #(.WIDTH(MOT_W), .DEPTH(MOTOR_DEPTH)) u_mot_ram (
    .clk(clk), .we(ring_we), .waddr(mot_slot_r), .wdata(mot_cor),
    .raddr(mot_raddr), .rdata(mot_rdata)
  );
  tcarf_ram #(.WIDTH(SRV_W), .DEPTH(SERVO_DEPTH)) u_srv_ram (
    .clk(clk), .we(ring_we), .waddr(srv_slot_r), .wdata(srv_cor),
    .raddr(srv_raddr), .rdata(srv_rdata)
  );

  // Read-side flags that travel with the registered read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bat_take_r <= 1'b0;
      mot_take_r <= 1'b0;
      srv_take_r <= 1'b0;
      first_r    <= 1'b0;
    end else begin
      bat_take_r <= walking && (cnt_r < BAT_D);
      mot_take_r <= walking && (cnt_r < MOT_D);
      srv_take_r <= walking && (cnt_r < SRV_D);
      first_r    <= (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    bat_vq_r <= bat_vld_r[bat_raddr];
    mot_vq_r <= mot_vld_r[mot_raddr];
    srv_vq_r <= srv_vld_r[srv_raddr];
  end

  // Entries never written read as their reset value.
  assign bat_rd = bat_vq_r ? bat_rdata : BAT_RESET;
  assign mot_rd = mot_vq_r ? mot_rdata : '0;
  assign srv_rd = srv_vq_r ? srv_rdata : '0;

  // Shared halving adder of each ring.
  assign bat_sum = {1'b0, bat_acc_r} + {1'b0, bat_rd};
  assign mot_sum = {1'b0, mot_acc_r} + {1'b0, mot_rd};
  assign srv_sum = {1'b0, srv_acc_r} + {1'b0, srv_rd};

  always_comb begin
    bat_acc_nxt = bat_acc_r;
    mot_acc_nxt = mot_acc_r;
    srv_acc_nxt = srv_acc_r;
    if (bat_take_r) bat_acc_nxt = first_r ? bat_rd : bat_sum[BAT_W:1];
    if (mot_take_r) mot_acc_nxt = first_r ? mot_rd : mot_sum[MOT_W:1];
    if (srv_take_r) srv_acc_nxt = first_r ? srv_rd : srv_sum[SRV_W:1];
  end

  always_ff @(posedge clk) begin
    bat_acc_r <= bat_acc_nxt;
    mot_acc_r <= mot_acc_nxt;
    srv_acc_r <= srv_acc_nxt;
  end

  // Motor average kept for the next tick's compensation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_mot_avg_r <= '0;
    end else if (walking && walk_done) begin
      last_mot_avg_r <= mot_acc_nxt;
    end
  end

  // Output register; a result parked in the hold state is already in the accumulators.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_bat_cor_r <= bat_cor_r;
      out_mot_cor_r <= mot_cor_r;
      out_srv_cor_r <= srv_cor_r;
      out_bat_flt_r <= bat_acc_nxt;
      out_mot_flt_r <= mot_acc_nxt;
      out_srv_flt_r <= srv_acc_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.battery_corrected = out_bat_cor_r;
  assign out_ch.motor_corrected   = out_mot_cor_r;
  assign out_ch.servo_corrected   = out_srv_cor_r;
  assign out_ch.battery_filtered  = out_bat_flt_r;
  assign out_ch.motor_filtered    = out_mot_flt_r;
  assign out_ch.servo_filtered    = out_srv_flt_r;

  // An accepted item always starts its correction cycle next.
  `TCARF_ASSERT_NXT(a_accept_to_corr, in_ch.valid && in_ready, state_r == tcarf_pkg::ST_CORR)
  // The walk counter never runs past the deepest ring.
  `TCARF_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_MAX)
  // Waiting after a walk only happens while the output register is occupied.
  `TCARF_ASSERT_IMP(a_hold_needs_out, state_r == tcarf_pkg::ST_HOLD, out_valid_r)

endmodule

[tb/sv/three_channel_adc_ring_filter_tb.sv]
// Self-checking testbench of the three-channel converter ring filter.
`timescale 1ns / 1ps

module three_channel_adc_ring_filter_tb;

  localparam int BATTERY_DEPTH  = tcarf_pkg::DEF_BATTERY_DEPTH;
  localparam int MOTOR_DEPTH    = tcarf_pkg::DEF_MOTOR_DEPTH;
  localparam int SERVO_DEPTH    = tcarf_pkg::DEF_SERVO_DEPTH;
  localparam int BATTERY_PRESET = tcarf_pkg::DEF_BATTERY_PRESET;
  localparam int RAW_W          = tcarf_pkg::RAW_W;
  localparam int BAT_W          = tcarf_pkg::BAT_W;
  localparam int MOT_W          = tcarf_pkg::MOT_W;
  localparam int SRV_W          = tcarf_pkg::SRV_W;
  localparam int CFG_IDX_W      = tcarf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W     = tcarf_pkg::CFG_DATA_W;
  localparam int RING_MAX       = 64;
  localparam int RAW_MAX        = 1023;
  localparam int MAX_DEPTH      = (BATTERY_DEPTH > MOTOR_DEPTH) ?
                                  ((BATTERY_DEPTH > SERVO_DEPTH) ? BATTERY_DEPTH : SERVO_DEPTH) :
                                  ((MOTOR_DEPTH > SERVO_DEPTH) ? MOTOR_DEPTH : SERVO_DEPTH);
  localparam int TICK_LATENCY   = MAX_DEPTH + 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 220;

  // Register indexes beyond the defined list.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

  // Values of one result item.
  typedef struct {
    logic [BAT_W-1:0] battery_corrected;
    logic [MOT_W-1:0] motor_corrected;
    logic [SRV_W-1:0] servo_corrected;
    logic [BAT_W-1:0] battery_filtered;
    logic [MOT_W-1:0] motor_filtered;
    logic [SRV_W-1:0] servo_filtered;
  } tick_result_t;

  logic clk;
  logic rst_n;

  tcarf_in_if  in_if ();
  tcarf_out_if out_if ();
  tcarf_cfg_if cfg_if ();

  three_channel_adc_ring_filter #(
    .BATTERY_DEPTH (BATTERY_DEPTH),
    .MOTOR_DEPTH   (MOTOR_DEPTH),
    .SERVO_DEPTH   (SERVO_DEPTH),
    .BATTERY_PRESET(BATTERY_PRESET)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if.sink),
    .out_ch(out_if.source),
    .cfg_ch(cfg_if.sink)
  );

  // Shadow copy of the block's registers and rings.
  int servo_cal;
  int seeder_on;
  int bat_ring [RING_MAX];
  int mot_ring [RING_MAX];
  int srv_ring [RING_MAX];
  int bat_slot;
  int mot_slot;
  int srv_slot;
  int prev_motor_avg;

  tick_result_t expected_ticks [$];
  int failures = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Puts the shadow state into its post-reset condition.
  task automatic reset_model();
    servo_cal = int'(tcarf_pkg::SERVO_CAL_RESET);
    seeder_on = int'(tcarf_pkg::SEEDER_RESET);
    for (int i = 0; i < RING_MAX; i++) begin
      bat_ring[i] = BATTERY_PRESET & 'h7FF;
      mot_ring[i] = 0;
      srv_ring[i] = 0;
    end
    bat_slot = 0;
    mot_slot = 0;
    srv_slot = 0;
    prev_motor_avg = 0;
  endtask

  // Cascaded halving average in storage order, starting at entry 0.
  function automatic int halving_average(input int ring [RING_MAX], input int depth);
    int acc;
    acc = ring[0];
    for (int i = 1; i < depth; i++) acc = (acc + ring[i]) >> 1;
    return acc;
  endfunction

  // Corrects one tick, writes the rings and returns the expected result item.
  function automatic tick_result_t predict_tick(input int bat_raw, input int mot_raw,
                                                input int srv_raw);
    tick_result_t r;
    int bat;
    int mot;
    int srv;
    int bat_avg;
    int mot_avg;
    int srv_avg;
    bat = bat_raw;
    if (seeder_on != 0) begin
      bat += (prev_motor_avg * int'(tcarf_pkg::COMP_MUL)) >> tcarf_pkg::COMP_SHIFT;
    end
    bat &= 'h7FF;
    mot = (mot_raw > int'(tcarf_pkg::MOTOR_OFFSET)) ?
          mot_raw - int'(tcarf_pkg::MOTOR_OFFSET) : 0;
    srv = srv_raw;
    if (seeder_on != 0) srv = (srv_raw > servo_cal) ? servo_cal : servo_cal - srv_raw;

    bat_ring[bat_slot] = bat;
    mot_ring[mot_slot] = mot;
    srv_ring[srv_slot] = srv;
    bat_slot = (bat_slot + 1 >= BATTERY_DEPTH) ? 0 : bat_slot + 1;
    mot_slot = (mot_slot + 1 >= MOTOR_DEPTH) ? 0 : mot_slot + 1;
    srv_slot = (srv_slot + 1 >= SERVO_DEPTH) ? 0 : srv_slot + 1;

    bat_avg = halving_average(bat_ring, BATTERY_DEPTH) & 'h7FF;
    mot_avg = halving_average(mot_ring, MOTOR_DEPTH) & 'h3FF;
    srv_avg = halving_average(srv_ring, SERVO_DEPTH) & 'h3FF;
    prev_motor_avg = mot_avg;

    r.battery_corrected = bat[BAT_W-1:0];
    r.motor_corrected   = mot[MOT_W-1:0];
    r.servo_corrected   = srv[SRV_W-1:0];
    r.battery_filtered  = bat_avg[BAT_W-1:0];
    r.motor_filtered    = mot_avg[MOT_W-1:0];
    r.servo_filtered    = srv_avg[SRV_W-1:0];
    return r;
  endfunction

  // Sends one tick item, with random idle cycles ahead of it.
  task automatic send_tick(input int bat, input int mot, input int srv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.battery_sample <= bat[RAW_W-1:0];
    in_if.motor_sample   <= mot[RAW_W-1:0];
    in_if.servo_sample   <= srv[RAW_W-1:0];
    do @(posedge clk); while (!in_if.ready);
    expected_ticks.push_back(predict_tick(bat, mot, srv));
  endtask

  // Stops sending and waits until every expected result item has come back.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (expected_ticks.size() != 0);
  endtask

  // Writes one configuration register; only called while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == tcarf_pkg::CFG_SERVO_CAL) servo_cal = int'(data);
    else if (idx == tcarf_pkg::CFG_SEEDER_MODE) seeder_on = int'(data[0]);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Seeder mode write with the unused upper data bits randomized.
  task automatic write_seeder_mode(input logic mode);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom());
    data[0] = mode;
    write_register(tcarf_pkg::CFG_SEEDER_MODE, data);
  endtask

  // Compares one field of a result item.
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk) begin : result_checker
    tick_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result item with no expected item waiting");
        failures++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("battery_corrected", int'(want.battery_corrected),
                    int'(out_if.battery_corrected));
        check_field("motor_corrected", int'(want.motor_corrected),
                    int'(out_if.motor_corrected));
        check_field("servo_corrected", int'(want.servo_corrected),
                    int'(out_if.servo_corrected));
        check_field("battery_filtered", int'(want.battery_filtered),
                    int'(out_if.battery_filtered));
        check_field("motor_filtered", int'(want.motor_filtered),
                    int'(out_if.motor_filtered));
        check_field("servo_filtered", int'(want.servo_filtered),
                    int'(out_if.servo_filtered));
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Register defaults after reset, sample extremes and both special cases.
  task automatic test_reset_defaults();
    send_tick(0, 0, 0);
    send_tick(RAW_MAX, RAW_MAX, RAW_MAX);
    send_tick(512, 31, 600);
    send_tick(100, 32, 601);
    send_tick(RAW_MAX, 30, 599);
    send_tick(0, RAW_MAX, 1);
    wait_for_results();
  endtask

  // Servo inversion at both extremes of the calibration reference.
  task automatic test_servo_calibration_extremes();
    write_register(tcarf_pkg::CFG_SERVO_CAL, 10'd0);
    send_tick(0, 0, 0);
    send_tick(RAW_MAX, RAW_MAX, 1);
    wait_for_results();
    write_register(tcarf_pkg::CFG_SERVO_CAL, 10'd1023);
    send_tick(5, 40, RAW_MAX);
    send_tick(RAW_MAX, 31, 0);
    wait_for_results();
  endtask

  // Servo and battery pass through unchanged outside seeder mode.
  task automatic test_passthrough_mode();
    write_seeder_mode(1'b0);
    send_tick(RAW_MAX, RAW_MAX, RAW_MAX);
    send_tick(0, 0, RAW_MAX);
    send_tick(700, 500, 0);
    wait_for_results();
    write_seeder_mode(1'b1);
  endtask

  // Writes to indexes beyond the register list leave the settings alone.
  task automatic test_unknown_registers();
    write_register(CFG_UNUSED_2, CFG_DATA_W'($urandom()));
    write_register(CFG_UNUSED_3, CFG_DATA_W'($urandom()));
    send_tick(300, 800, 900);
    send_tick(RAW_MAX, 0, 200);
    wait_for_results();
  endtask

  // One phase of random ticks, biased toward the motor offset and the servo reference.
  task automatic run_random_phase(input int send_pct, input int stall_pct);
    int bat;
    int mot;
    int srv;
    int sel;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      bat = int'($urandom_range(RAW_MAX));
      mot = int'($urandom_range(RAW_MAX));
      srv = int'($urandom_range(RAW_MAX));
      sel = int'($urandom_range(9));
      if (sel >= 6 && sel <= 7) begin
        mot = int'($urandom_range(40, 20));
      end else if (sel >= 8) begin
        srv = servo_cal + int'($urandom_range(4)) - 2;
        if (srv < 0) srv = 0;
        if (srv > RAW_MAX) srv = RAW_MAX;
      end
      send_tick(bat, mot, srv);
    end
    wait_for_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Random ticks under several settings and idling patterns.
  task automatic test_random_phases();
    write_register(tcarf_pkg::CFG_SERVO_CAL, CFG_DATA_W'($urandom_range(RAW_MAX)));
    run_random_phase(0, 0);
    write_register(tcarf_pkg::CFG_SERVO_CAL, 10'd1023);
    run_random_phase(51, 0);
    write_register(tcarf_pkg::CFG_SERVO_CAL, 10'd0);
    write_seeder_mode(1'b0);
    run_random_phase(0, 51);
    write_register(tcarf_pkg::CFG_SERVO_CAL, CFG_DATA_W'($urandom_range(RAW_MAX)));
    write_seeder_mode(1'b1);
    run_random_phase(23, 23);
  endtask

  // Test sequence.
  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.battery_sample <= '0;
    in_if.motor_sample   <= '0;
    in_if.servo_sample   <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= '0;
    cfg_if.data          <= '0;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_servo_calibration_extremes();
    test_passthrough_mode();
    test_unknown_registers();
    test_random_phases();

    wait_for_results();
    repeat (TICK_LATENCY + 10) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/tcarf_pkg.sv
rtl/tcarf_in_if.sv
rtl/tcarf_out_if.sv
rtl/tcarf_cfg_if.sv
rtl/tcarf_ram.sv
rtl/three_channel_adc_ring_filter.sv
tb/sv/three_channel_adc_ring_filter_tb.sv
